// File: hdl/ttao_pkg.sv
package ttao_pkg;

	// Field and register widths
	localparam int PRICE_W       = 48;
	localparam int FAC_W         = 32;
	localparam int PROB_W        = 25;
	localparam int STEP_W        = 9;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_W         = 48;
	localparam int PROD_W        = 56;
	localparam int RES_W         = 57;
	localparam int ACC_W         = 59;
	localparam int DEF_MAX_STEPS = 256;

	// Fixed-point constants
	localparam logic [PROB_W-1:0] ONE_Q24  = PROB_W'(25'd16777216);
	localparam logic [RES_W-1:0]  HALF_Q24 = RES_W'(57'd8388608);

	// Register reset values
	localparam logic [FAC_W-1:0]  RST_UP_FACTOR = FAC_W'(32'd16777216);
	localparam logic [FAC_W-1:0]  RST_DN_FACTOR = FAC_W'(32'd16777216);
	localparam logic [PROB_W-1:0] RST_DISCOUNT  = ONE_Q24;
	localparam logic [STEP_W-1:0] RST_STEPS     = STEP_W'(9'd16);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACTOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROB_UP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROB_DOWN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STRIKE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PUT_MODE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 3'd7;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INIT,
		ST_FWD_UP,
		ST_FWD_UP_WAIT,
		ST_FWD_UP_WR,
		ST_FWD_DN,
		ST_FWD_DN_WAIT,
		ST_FWD_DN_WR,
		ST_COL_RD0,
		ST_COL_RD1,
		ST_COL_LOAD,
		ST_NODE_RD,
		ST_NODE_LOAD,
		ST_MUL,
		ST_MUL_WAIT,
		ST_NODE_WR,
		ST_RES_RD,
		ST_DONE
	} state_t;

	// Clamp a wide sum to the 48-bit price range
	function automatic logic [PRICE_W-1:0] sat48(input logic [ACC_W-1:0] x);
		logic [ACC_W-1:0] lim;
		lim = ACC_W'({PRICE_W{1'b1}});
		return (x > lim) ? {PRICE_W{1'b1}} : x[PRICE_W-1:0];
	endfunction

	// Immediate exercise value, floored at zero
	function automatic logic [PRICE_W-1:0] exercise(input logic [PRICE_W-1:0] price,
			input logic [PRICE_W-1:0] k, input logic put);
		logic [PRICE_W-1:0] r;
		r = '0;
		if (put) begin
			if (k > price) r = k - price;
		end else begin
			if (price > k) r = price - k;
		end
		return r;
	endfunction

endpackage

// File: hdl/trinomial_tree_american_option.sv
// American call or put priced on a recombining trinomial lattice of n steps
// (n = step_count, capped at MAX_STEPS). One spot price request in, one option
// value request out. Node prices and node values live in two synchronous
// memories of 2*MAX_STEPS+1 entries; a single shared rounding multiplier
// (two-stage pipeline) does all products one at a time. A new request is
// taken only after the previous result is loaded out: the price ladder is
// built level by level, neighbor values are primed per column and backward
// induction runs node by node, four multiplies per node. The user writes
// configuration only while the block is idle; the block does not enforce it.
module trinomial_tree_american_option #(
	parameter int MAX_STEPS = ttao_pkg::DEF_MAX_STEPS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [ttao_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ttao_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ttao_pkg::PRICE_W-1:0]      spot_price,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ttao_pkg::PRICE_W-1:0]      option_value
);

	localparam int DEPTH = 2 * MAX_STEPS + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(MAX_STEPS + 1);
	localparam int PW    = ttao_pkg::PRICE_W;

	// Configuration registers
	logic [ttao_pkg::FAC_W-1:0]  up_factor_q, down_factor_q;
	logic [ttao_pkg::PROB_W-1:0] prob_up_q, prob_down_q, discount_q;
	logic [PW-1:0]               strike_q;
	logic                        put_mode_q;
	logic [ttao_pkg::STEP_W-1:0] step_count_q;

	ttao_pkg::state_t state_q, state_d;

	logic [NW-1:0]                n_q, k_q;
	logic [ttao_pkg::PROB_W-1:0]  pm_q;
	logic [PW-1:0]                spot_q, up_p_q, dn_p_q;
	logic [AW-1:0]                lo_q, hi_q, idx_q;
	logic [PW-1:0]                prev_q, cur_q, nxt_q, pr_q, cont_q;
	logic [ttao_pkg::ACC_W-1:0]   acc_q;
	logic [1:0]                   term_q;
	logic                         out_valid_q;
	logic [PW-1:0]                out_q;

	// Memories
	logic [PW-1:0] price_mem [DEPTH];
	logic [PW-1:0] value_mem [DEPTH];
	logic [PW-1:0] p_rd_q, v_rd_q;
	logic          p_we, v_we, p_re, v_re;
	logic [AW-1:0] p_waddr, v_waddr, p_raddr, v_raddr;
	logic [PW-1:0] p_wdata, v_wdata;

	// Multiplier
	logic                          mul_go, mul_v_s1, mul_v_s2;
	logic [PW-1:0]                 mul_a;
	logic [ttao_pkg::FAC_W-1:0]    mul_f;
	logic [ttao_pkg::PROD_W-1:0]   plo_s1, phi_s1;
	logic [ttao_pkg::RES_W-1:0]    res_s2;

	logic [NW-1:0]               n_next;
	logic [ttao_pkg::PROB_W:0]   psum;
	logic [AW-1:0]               addr_up, addr_dn;
	logic                        in_take, out_take, out_load;

	assign n_next = (32'(step_count_q) > 32'(MAX_STEPS)) ? NW'(MAX_STEPS) : NW'(step_count_q);
	assign psum    = (ttao_pkg::PROB_W+1)'(prob_up_q) + (ttao_pkg::PROB_W+1)'(prob_down_q);
	assign addr_up = AW'(n_q) + AW'(k_q);
	assign addr_dn = AW'(n_q) - AW'(k_q);
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_load = (state_q == ttao_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	assign in_stall     = (state_q != ttao_pkg::ST_IDLE);
	assign out_valid    = out_valid_q;
	assign option_value = out_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_factor_q   <= ttao_pkg::RST_UP_FACTOR;
			down_factor_q <= ttao_pkg::RST_DN_FACTOR;
			prob_up_q     <= '0;
			prob_down_q   <= '0;
			discount_q    <= ttao_pkg::RST_DISCOUNT;
			strike_q      <= '0;
			put_mode_q    <= 1'b0;
			step_count_q  <= ttao_pkg::RST_STEPS;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ttao_pkg::REG_UP_FACTOR:   up_factor_q   <= cfg_data[ttao_pkg::FAC_W-1:0];
				ttao_pkg::REG_DOWN_FACTOR: down_factor_q <= cfg_data[ttao_pkg::FAC_W-1:0];
				ttao_pkg::REG_PROB_UP:     prob_up_q     <= cfg_data[ttao_pkg::PROB_W-1:0];
				ttao_pkg::REG_PROB_DOWN:   prob_down_q   <= cfg_data[ttao_pkg::PROB_W-1:0];
				ttao_pkg::REG_DISCOUNT:    discount_q    <= cfg_data[ttao_pkg::PROB_W-1:0];
				ttao_pkg::REG_STRIKE:      strike_q      <= cfg_data[PW-1:0];
				ttao_pkg::REG_PUT_MODE:    put_mode_q    <= cfg_data[0];
				ttao_pkg::REG_STEP_COUNT:  step_count_q  <= cfg_data[ttao_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttao_pkg::ST_IDLE:        if (in_take) state_d = ttao_pkg::ST_INIT;
			ttao_pkg::ST_INIT:
				state_d = (n_q == '0) ? ttao_pkg::ST_RES_RD : ttao_pkg::ST_FWD_UP;
			ttao_pkg::ST_FWD_UP:      state_d = ttao_pkg::ST_FWD_UP_WAIT;
			ttao_pkg::ST_FWD_UP_WAIT: if (mul_v_s2) state_d = ttao_pkg::ST_FWD_UP_WR;
			ttao_pkg::ST_FWD_UP_WR:   state_d = ttao_pkg::ST_FWD_DN;
			ttao_pkg::ST_FWD_DN:      state_d = ttao_pkg::ST_FWD_DN_WAIT;
			ttao_pkg::ST_FWD_DN_WAIT: if (mul_v_s2) state_d = ttao_pkg::ST_FWD_DN_WR;
			ttao_pkg::ST_FWD_DN_WR:
				state_d = (k_q == n_q) ? ttao_pkg::ST_COL_RD0 : ttao_pkg::ST_FWD_UP;
			ttao_pkg::ST_COL_RD0:     state_d = ttao_pkg::ST_COL_RD1;
			ttao_pkg::ST_COL_RD1:     state_d = ttao_pkg::ST_COL_LOAD;
			ttao_pkg::ST_COL_LOAD:    state_d = ttao_pkg::ST_NODE_RD;
			ttao_pkg::ST_NODE_RD:     state_d = ttao_pkg::ST_NODE_LOAD;
			ttao_pkg::ST_NODE_LOAD:   state_d = ttao_pkg::ST_MUL;
			ttao_pkg::ST_MUL:         state_d = ttao_pkg::ST_MUL_WAIT;
			ttao_pkg::ST_MUL_WAIT:
				if (mul_v_s2) state_d = (term_q == 2'd3) ? ttao_pkg::ST_NODE_WR : ttao_pkg::ST_MUL;
			ttao_pkg::ST_NODE_WR:
				if (idx_q != hi_q) state_d = ttao_pkg::ST_NODE_RD;
				else if (lo_q >= hi_q) state_d = ttao_pkg::ST_RES_RD;
				else state_d = ttao_pkg::ST_COL_RD0;
			ttao_pkg::ST_RES_RD:      state_d = ttao_pkg::ST_DONE;
			ttao_pkg::ST_DONE:        if (out_load) state_d = ttao_pkg::ST_IDLE;
			default:                  state_d = ttao_pkg::ST_IDLE;
		endcase
	end

	// Memory ports and multiplier issue
	always_comb begin
		p_we = 1'b0; p_waddr = '0; p_wdata = '0;
		v_we = 1'b0; v_waddr = '0; v_wdata = '0;
		p_re = 1'b0; p_raddr = '0;
		v_re = 1'b0; v_raddr = '0;
		mul_go = 1'b0; mul_a = '0; mul_f = '0;
		unique case (state_q)
			ttao_pkg::ST_INIT: begin
				p_we = 1'b1; p_waddr = AW'(n_q); p_wdata = spot_q;
				v_we = 1'b1; v_waddr = AW'(n_q);
				v_wdata = ttao_pkg::exercise(spot_q, strike_q, put_mode_q);
			end
			ttao_pkg::ST_FWD_UP: begin
				mul_go = 1'b1; mul_a = up_p_q; mul_f = up_factor_q;
			end
			ttao_pkg::ST_FWD_UP_WR: begin
				p_we = 1'b1; p_waddr = addr_up; p_wdata = up_p_q;
				v_we = 1'b1; v_waddr = addr_up;
				v_wdata = ttao_pkg::exercise(up_p_q, strike_q, put_mode_q);
			end
			ttao_pkg::ST_FWD_DN: begin
				mul_go = 1'b1; mul_a = dn_p_q; mul_f = down_factor_q;
			end
			ttao_pkg::ST_FWD_DN_WR: begin
				p_we = 1'b1; p_waddr = addr_dn; p_wdata = dn_p_q;
				v_we = 1'b1; v_waddr = addr_dn;
				v_wdata = ttao_pkg::exercise(dn_p_q, strike_q, put_mode_q);
			end
			ttao_pkg::ST_COL_RD0: begin
				v_re = 1'b1; v_raddr = lo_q - AW'(1);
			end
			ttao_pkg::ST_COL_RD1: begin
				v_re = 1'b1; v_raddr = lo_q;
			end
			ttao_pkg::ST_NODE_RD: begin
				v_re = 1'b1; v_raddr = idx_q + AW'(1);
				p_re = 1'b1; p_raddr = idx_q;
			end
			ttao_pkg::ST_MUL: begin
				mul_go = 1'b1;
				unique case (term_q)
					2'd0: begin mul_a = nxt_q;  mul_f = ttao_pkg::FAC_W'(prob_up_q);   end
					2'd1: begin mul_a = cur_q;  mul_f = ttao_pkg::FAC_W'(pm_q);        end
					2'd2: begin mul_a = prev_q; mul_f = ttao_pkg::FAC_W'(prob_down_q); end
					default: begin
						mul_a = ttao_pkg::sat48(acc_q);
						mul_f = ttao_pkg::FAC_W'(discount_q);
					end
				endcase
			end
			ttao_pkg::ST_NODE_WR: begin
				v_we = 1'b1; v_waddr = idx_q;
				v_wdata = (cont_q > ttao_pkg::exercise(pr_q, strike_q, put_mode_q)) ?
					cont_q : ttao_pkg::exercise(pr_q, strike_q, put_mode_q);
			end
			ttao_pkg::ST_RES_RD: begin
				v_re = 1'b1; v_raddr = AW'(n_q);
			end
			default: ;
		endcase
	end

	// Node memories
	always_ff @(posedge clk) begin
		if (p_we) price_mem[p_waddr] <= p_wdata;
		if (p_re) p_rd_q <= price_mem[p_raddr];
	end

	always_ff @(posedge clk) begin
		if (v_we) value_mem[v_waddr] <= v_wdata;
		if (v_re) v_rd_q <= value_mem[v_raddr];
	end

	// Rounding multiplier: split products, then round and add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s1 <= 1'b0;
			mul_v_s2 <= 1'b0;
		end else begin
			mul_v_s1 <= mul_go;
			mul_v_s2 <= mul_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			plo_s1 <= ttao_pkg::PROD_W'(mul_a[23:0]) * ttao_pkg::PROD_W'(mul_f);
			phi_s1 <= ttao_pkg::PROD_W'(mul_a[47:24]) * ttao_pkg::PROD_W'(mul_f);
		end
		if (mul_v_s1) begin
			res_s2 <= ttao_pkg::RES_W'(phi_s1)
				+ ((ttao_pkg::RES_W'(plo_s1) + ttao_pkg::HALF_Q24) >> 24);
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ttao_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// Hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Lattice datapath
	always_ff @(posedge clk) begin
		if (out_load) out_q <= v_rd_q;
		unique case (state_q)
			ttao_pkg::ST_IDLE: if (in_take) begin
				spot_q <= spot_price;
				up_p_q <= spot_price;
				dn_p_q <= spot_price;
				n_q    <= n_next;
				k_q    <= NW'(1);
				pm_q   <= (psum >= (ttao_pkg::PROB_W+1)'(ttao_pkg::ONE_Q24)) ? '0 :
					ttao_pkg::PROB_W'((ttao_pkg::PROB_W+1)'(ttao_pkg::ONE_Q24) - psum);
			end
			ttao_pkg::ST_FWD_UP_WAIT: if (mul_v_s2) up_p_q <= ttao_pkg::sat48(ttao_pkg::ACC_W'(res_s2));
			ttao_pkg::ST_FWD_DN_WAIT: if (mul_v_s2) dn_p_q <= ttao_pkg::sat48(ttao_pkg::ACC_W'(res_s2));
			ttao_pkg::ST_FWD_DN_WR: begin
				k_q  <= k_q + NW'(1);
				lo_q <= AW'(1);
				hi_q <= AW'(2) * AW'(n_q) - AW'(1);
			end
			ttao_pkg::ST_COL_RD1:  prev_q <= v_rd_q;
			ttao_pkg::ST_COL_LOAD: begin
				cur_q <= v_rd_q;
				idx_q <= lo_q;
			end
			ttao_pkg::ST_NODE_LOAD: begin
				nxt_q  <= v_rd_q;
				pr_q   <= p_rd_q;
				acc_q  <= '0;
				term_q <= 2'd0;
			end
			ttao_pkg::ST_MUL_WAIT: if (mul_v_s2) begin
				if (term_q == 2'd3) begin
					cont_q <= ttao_pkg::sat48(ttao_pkg::ACC_W'(res_s2));
				end else begin
					acc_q  <= acc_q + ttao_pkg::ACC_W'(res_s2);
					term_q <= term_q + 2'd1;
				end
			end
			ttao_pkg::ST_NODE_WR: begin
				prev_q <= cur_q;
				cur_q  <= nxt_q;
				if (idx_q != hi_q) begin
					idx_q <= idx_q + AW'(1);
				end else begin
					lo_q <= lo_q + AW'(1);
					hi_q <= hi_q - AW'(1);
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_v_s2 |-> (state_q == ttao_pkg::ST_FWD_UP_WAIT || state_q == ttao_pkg::ST_FWD_DN_WAIT
			|| state_q == ttao_pkg::ST_MUL_WAIT))
		else $error("multiplier result outside a wait state");

	a_mul_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		mul_go |-> (!mul_v_s1 && !mul_v_s2))
		else $error("multiply issued while another is in flight");

	a_node_in_column: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttao_pkg::ST_NODE_WR) |-> (idx_q >= lo_q && idx_q <= hi_q))
		else $error("node write outside the active column");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ttao_pkg::ST_DONE))
		else $error("result raised outside the done state");
`endif

endmodule

// File: dv/trinomial_tree_american_option_tb.sv
module trinomial_tree_american_option_tb;

	localparam int LATTICE_N    = 2 * ttao_pkg::DEF_MAX_STEPS + 1;
	localparam int STALL_LIMIT  = 400000;
	localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] Q24_ONE = 64'd16777216;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_write;
	logic [ttao_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ttao_pkg::CFG_W-1:0]     cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic [ttao_pkg::PRICE_W-1:0]   spot_price;
	logic                           out_valid;
	logic                           out_stall;
	logic [ttao_pkg::PRICE_W-1:0]   option_value;

	// Shadow copy of the register file
	logic [63:0] sh_up, sh_down, sh_pu, sh_pd, sh_disc, sh_strike, sh_put, sh_steps;

	logic [63:0] node_px [0:LATTICE_N-1];
	logic [63:0] node_val [0:LATTICE_N-1];

	logic [ttao_pkg::PRICE_W-1:0] pending_values [$];
	int                           error_count;
	int                           sent_count;
	int                           recv_count;
	int                           idle_cycles;
	int                           rx_wait;
	bit                           no_idle;

	trinomial_tree_american_option dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.spot_price(spot_price),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.option_value(option_value)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Rounded Q24 product, ties away from zero
	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] f);
		return (a >> 24) * f + (((a & (Q24_ONE - 1)) * f + 64'd8388608) >> 24);
	endfunction

	function automatic logic [63:0] clamp48(input logic [63:0] x);
		return (x > MASK48) ? MASK48 : x;
	endfunction

	function automatic logic [63:0] payoff(input logic [63:0] px);
		if (sh_put != 0)
			return (sh_strike > px) ? sh_strike - px : 64'd0;
		return (px > sh_strike) ? px - sh_strike : 64'd0;
	endfunction

	// Build the price ladder, seed the leaves, then roll values back to the root
	function automatic logic [ttao_pkg::PRICE_W-1:0] lattice_value(input logic [63:0] spot);
		int n, k, col, lo, hi;
		logic [63:0] pm, psum, prev_old, cur_old, acc, cont, ex;
		n = (sh_steps > ttao_pkg::DEF_MAX_STEPS) ? ttao_pkg::DEF_MAX_STEPS : int'(sh_steps);
		psum = sh_pu + sh_pd;
		pm = (psum >= Q24_ONE) ? 64'd0 : Q24_ONE - psum;
		node_px[n] = spot;
		for (k = 1; k <= n; k++) begin
			node_px[n + k] = clamp48(qmul(node_px[n + k - 1], sh_up));
			node_px[n - k] = clamp48(qmul(node_px[n - k + 1], sh_down));
		end
		for (k = 0; k <= 2 * n; k++)
			node_val[k] = payoff(node_px[k]);
		for (col = n - 1; col >= 0; col--) begin
			lo = n - col;
			hi = n + col;
			prev_old = node_val[lo - 1];
			for (k = lo; k <= hi; k++) begin
				cur_old = node_val[k];
				acc = qmul(node_val[k + 1], sh_pu) + qmul(cur_old, pm) + qmul(prev_old, sh_pd);
				cont = clamp48(qmul(clamp48(acc), sh_disc));
				ex = payoff(node_px[k]);
				node_val[k] = (cont > ex) ? cont : ex;
				prev_old = cur_old;
			end
		end
		return node_val[n][ttao_pkg::PRICE_W-1:0];
	endfunction

	// Let the block drain before touching its registers
	task automatic wait_drained();
		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ttao_pkg::CFG_IDX_W-1:0] idx,
			input logic [63:0] data);
		wait_drained();
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data[ttao_pkg::CFG_W-1:0];
		case (idx)
			ttao_pkg::REG_UP_FACTOR:   sh_up     = data & 64'hFFFF_FFFF;
			ttao_pkg::REG_DOWN_FACTOR: sh_down   = data & 64'hFFFF_FFFF;
			ttao_pkg::REG_PROB_UP:     sh_pu     = data & 64'h1FF_FFFF;
			ttao_pkg::REG_PROB_DOWN:   sh_pd     = data & 64'h1FF_FFFF;
			ttao_pkg::REG_DISCOUNT:    sh_disc   = data & 64'h1FF_FFFF;
			ttao_pkg::REG_STRIKE:      sh_strike = data & MASK48;
			ttao_pkg::REG_PUT_MODE:    sh_put    = data & 64'h1;
			ttao_pkg::REG_STEP_COUNT:  sh_steps  = data & 64'h1FF;
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic load_config(input logic [63:0] up, input logic [63:0] dn,
			input logic [63:0] pu, input logic [63:0] pd, input logic [63:0] disc,
			input logic [63:0] k, input logic [63:0] put, input logic [63:0] steps);
		write_reg(ttao_pkg::REG_UP_FACTOR, up);
		write_reg(ttao_pkg::REG_DOWN_FACTOR, dn);
		write_reg(ttao_pkg::REG_PROB_UP, pu);
		write_reg(ttao_pkg::REG_PROB_DOWN, pd);
		write_reg(ttao_pkg::REG_DISCOUNT, disc);
		write_reg(ttao_pkg::REG_STRIKE, k);
		write_reg(ttao_pkg::REG_PUT_MODE, put);
		write_reg(ttao_pkg::REG_STEP_COUNT, steps);
	endtask

	// Offer one spot price request and record its expected value on acceptance
	task automatic send_spot(input logic [63:0] spot);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		repeat (gap) @(posedge clk);
		@(posedge clk);
		in_valid   <= 1'b1;
		spot_price <= spot[ttao_pkg::PRICE_W-1:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		in_valid <= 1'b0;
		pending_values = {pending_values, lattice_value(spot & MASK48)};
		sent_count++;
	endtask

	function automatic logic [63:0] rand48();
		return {$urandom_range(0, 65535), $urandom()} & MASK48;
	endfunction

	// Check results and draw receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				recv_count++;
				if (pending_values.size() == 0) begin
					$display("%0t: unexpected option_value %h", $time, option_value);
					error_count++;
				end else begin
					if (option_value !== pending_values[0]) begin
						$display("%0t: option_value expected %h actual %h",
							$time, pending_values[0], option_value);
						error_count++;
					end
					void'(pending_values.pop_front());
				end
				rx_wait = no_idle ? 0 : $urandom_range(0, 9);
			end else if (out_valid && rx_wait > 0) begin
				rx_wait--;
			end
			out_stall <= (rx_wait > 0);
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic test_reset_defaults();
		no_idle = 1'b1;
		send_spot(64'd0);
		send_spot(MASK48);
		send_spot(64'h0000_0100_0000);
		no_idle = 1'b0;
	endtask

	task automatic test_step_extremes();
		// zero steps gives the payoff at the spot
		load_config(64'd17000000, 64'd16557000, 64'd5000000, 64'd4000000,
			64'd16700000, 64'h0000_6400_0000, 64'd1, 64'd0);
		send_spot(64'h0000_5A00_0000);
		write_reg(ttao_pkg::REG_STEP_COUNT, 64'd1);
		send_spot(64'h0000_5A00_0000);
		write_reg(ttao_pkg::REG_STEP_COUNT, 64'd24);
		send_spot(64'h0000_6000_0000);
	endtask

	task automatic test_saturation();
		load_config(64'hFFFF_FFFF, 64'd0, 64'h1FF_FFFF, 64'h1FF_FFFF,
			64'h1FF_FFFF, 64'd0, 64'd0, 64'd3);
		send_spot(MASK48);
		send_spot(64'h0000_0001_0000);
		write_reg(ttao_pkg::REG_PUT_MODE, 64'd1);
		write_reg(ttao_pkg::REG_STRIKE, MASK48);
		send_spot(64'd0);
		send_spot(MASK48);
	endtask

	task automatic test_probabilities();
		// up and down probabilities summing above one drop the middle path
		load_config(64'd18000000, 64'd15600000, 64'd12000000, 64'd9000000,
			64'd16000000, 64'h0000_6400_0000, 64'd0, 64'd4);
		send_spot(64'h0000_6400_0000);
		write_reg(ttao_pkg::REG_PROB_UP, 64'd0);
		write_reg(ttao_pkg::REG_PROB_DOWN, 64'd0);
		send_spot(64'h0000_7000_0000);
		write_reg(ttao_pkg::REG_DISCOUNT, 64'd0);
		send_spot(64'h0000_7000_0000);
		write_reg(ttao_pkg::REG_PROB_UP, Q24_ONE);
		write_reg(ttao_pkg::REG_DISCOUNT, Q24_ONE);
		write_reg(ttao_pkg::REG_PUT_MODE, 64'd1);
		send_spot(64'h0000_5000_0000);
		write_reg(ttao_pkg::REG_PROB_DOWN, Q24_ONE);
		send_spot(64'h0000_5000_0000);
	endtask

	task automatic test_random_items();
		int i;
		logic [63:0] up, spot;
		for (i = 0; i < 100; i++) begin
			if (i % 8 == 0) begin
				up = 64'd16777216 + $urandom_range(0, 3000000);
				if ($urandom_range(0, 5) == 0) up = $urandom();
				load_config(up,
					($urandom_range(0, 5) == 0) ? $urandom() :
						(64'd281474976710656 / up),
					($urandom_range(0, 6) == 0) ? $urandom_range(0, 33554431) :
						$urandom_range(0, 8388608),
					($urandom_range(0, 6) == 0) ? $urandom_range(0, 33554431) :
						$urandom_range(0, 8388608),
					($urandom_range(0, 6) == 0) ? $urandom_range(0, 33554431) :
						$urandom_range(16000000, 16777216),
					($urandom_range(0, 4) == 0) ? rand48() :
						(64'($urandom_range(1, 255)) << 24),
					$urandom_range(0, 1),
					($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8));
				no_idle = ($urandom_range(0, 3) == 0);
			end
			spot = ($urandom_range(0, 4) == 0) ? rand48() :
				((64'($urandom_range(1, 255)) << 24) | 64'($urandom_range(0, 16777215)));
			send_spot(spot);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_write  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		spot_price = '0;
		out_stall  = 1'b0;
		error_count = 0;
		sent_count  = 0;
		recv_count  = 0;
		idle_cycles = 0;
		rx_wait     = 0;
		no_idle     = 1'b0;
		sh_up = Q24_ONE; sh_down = Q24_ONE; sh_pu = 0; sh_pd = 0;
		sh_disc = Q24_ONE; sh_strike = 0; sh_put = 0; sh_steps = 16;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_step_extremes();
		test_saturation();
		test_probabilities();
		test_random_items();

		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Priced %0d spot requests, %0d values returned, %0d mismatches",
			sent_count, recv_count, error_count);
		$display("Covered reset defaults, step extremes, saturation, probability edges, random");
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
hdl/ttao_pkg.sv
hdl/trinomial_tree_american_option.sv
dv/trinomial_tree_american_option_tb.sv
